[sv/plt_pkg.sv]
// Types and constants shared by the proximity lap timer.
package plt_pkg;

    // Lap table depth.
    localparam int LAPS = 4;

    localparam int DIST_W   = 17;
    localparam int TIME_W   = 32;
    localparam int TIDX_W   = (LAPS > 1) ? $clog2(LAPS) : 1;
    localparam int CNT_W    = $clog2(LAPS + 1);
    localparam int APB_AW   = 3;
    localparam int APB_DW   = 32;

    localparam logic [DIST_W-1:0] ENTER_RESET = DIST_W'(1000);
    localparam logic [DIST_W-1:0] EXIT_RESET  = DIST_W'(1200);

    typedef enum logic [2:0] {
        ACT_SAMPLE   = 3'd0,
        ACT_ARM_NORM = 3'd1,
        ACT_ARM_TEST = 3'd2,
        ACT_STOP     = 3'd3,
        ACT_PING     = 3'd4,
        ACT_READ_LAP = 3'd5
    } action_t;

    typedef enum logic [2:0] {
        EV_STATUS  = 3'd0,
        EV_STARTED = 3'd1,
        EV_LAP     = 3'd2,
        EV_END     = 3'd3,
        EV_PONG    = 3'd4,
        EV_READOUT = 3'd5
    } event_t;

    // Register indexes on the APB port (byte address bit 2).
    typedef enum logic {
        REG_ENTER = 1'b0,
        REG_EXIT  = 1'b1
    } reg_idx_t;

    typedef struct packed {
        logic [2:0]        action;
        logic [DIST_W-1:0] distance;
        logic [TIME_W-1:0] now_ms;
        logic [1:0]        lap_select;
    } lap_req_t;

    typedef struct packed {
        logic [2:0]        event_res;
        logic [1:0]        lap_index;
        logic [TIME_W-1:0] lap_time_ms;
        logic              is_armed;
        logic              is_inside;
        logic [2:0]        laps_done;
        logic              in_test;
        logic              last;
    } lap_rsp_t;

    // Results caused by one request: one or two.
    typedef struct packed {
        lap_rsp_t first;
        lap_rsp_t second;
        logic     two;
    } rsp_pair_t;

endpackage

[sv/proximity_lap_timer.sv]
// Proximity lap timer: gate detector, lap table and result queue.
//
// Usage:
//   Requests enter on req_valid/req_stall/req_data. Action sample feeds a
//   distance with its ms timestamp; other actions arm normal or test mode,
//   stop, ping, or read one lap table entry. Results leave on
//   rsp_valid/rsp_stall/rsp_data, one or two per request, the final one
//   flagged by last (a lap that completes a normal run is followed by end).
//   Thresholds are written over the APB port: 0x0 enter, 0x4 exit.
// Timing:
//   The whole state update is done in the cycle a request is accepted; its
//   results are registered into the result queue. One request per cycle is
//   taken while the queue is not full, so the rate is set by the output side,
//   which moves one result per cycle while rsp_stall is low; a request that
//   yields lap plus end keeps its queue entry until both results have left.
// Reset:
//   Disarmed, table cleared, thresholds 1000 and 1200, queue empty.
// Stall:
//   Results wait in a two-entry result queue. req_stall rises only when
//   both entries hold undelivered results.
module proximity_lap_timer (
    input  logic                     clk,
    input  logic                     rst_n,
    // APB configuration
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [plt_pkg::APB_AW-1:0] paddr,
    input  logic [plt_pkg::APB_DW-1:0] pwdata,
    output logic [plt_pkg::APB_DW-1:0] prdata,
    output logic                     pready,
    // request channel
    input  logic                     req_valid,
    output logic                     req_stall,
    input  plt_pkg::lap_req_t        req_data,
    // result channel
    output logic                     rsp_valid,
    input  logic                     rsp_stall,
    output plt_pkg::lap_rsp_t        rsp_data
);

    localparam int DW = plt_pkg::DIST_W;
    localparam int TW = plt_pkg::TIME_W;
    localparam int IW = plt_pkg::TIDX_W;
    localparam int CW = plt_pkg::CNT_W;

    // ---------------- configuration ----------------
    logic [DW-1:0] enter_thr_reg;
    logic [DW-1:0] exit_thr_reg;
    logic          cfg_wr;
    logic          cfg_sel;

    function automatic logic [plt_pkg::APB_DW-1:0] APB_PAD(input logic [DW-1:0] v);
        return plt_pkg::APB_DW'(v);
    endfunction

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = paddr[2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enter_thr_reg <= plt_pkg::ENTER_RESET;
            exit_thr_reg  <= plt_pkg::EXIT_RESET;
        end
        else if (cfg_wr)
        begin
            unique case (cfg_sel)
                plt_pkg::REG_ENTER: enter_thr_reg <= pwdata[DW-1:0];
                plt_pkg::REG_EXIT:  exit_thr_reg  <= pwdata[DW-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        unique case (cfg_sel)
            plt_pkg::REG_ENTER: prdata = APB_PAD(enter_thr_reg);
            plt_pkg::REG_EXIT:  prdata = APB_PAD(exit_thr_reg);
            default:            prdata = '0;
        endcase
    end

    // ---------------- timer state ----------------
    logic          armed_reg,   armed_next;
    logic          inside_reg,  inside_next;
    logic          test_reg,    test_next;
    logic          started_reg, started_next;
    logic [TW-1:0] start_reg,   start_next;
    logic [CW-1:0] count_reg,   count_next;
    logic [TW-1:0] table_reg  [plt_pkg::LAPS];
    logic [TW-1:0] table_next [plt_pkg::LAPS];

    logic              req_fire;
    plt_pkg::rsp_pair_t pair;

    // event of the gate crossing and its fields
    logic          ev_hit;
    logic [2:0]    ev_code;
    logic [1:0]    ev_idx;
    logic [TW-1:0] ev_time;
    logic          end_hit;
    logic [TW-1:0] lap_ms;
    logic [IW-1:0] sel_idx;
    logic          sel_ok;
    logic [2:0]    misc_code;
    logic [1:0]    misc_idx;
    logic [TW-1:0] misc_time;

    assign lap_ms  = req_data.now_ms - start_reg;
    assign sel_idx = IW'(req_data.lap_select);
    assign sel_ok  = 32'(req_data.lap_select) < 32'(plt_pkg::LAPS);

    always_comb
    begin
        armed_next   = armed_reg;
        inside_next  = inside_reg;
        test_next    = test_reg;
        started_next = started_reg;
        start_next   = start_reg;
        count_next   = count_reg;
        table_next   = table_reg;
        ev_hit       = 1'b0;
        ev_code      = plt_pkg::EV_STATUS;
        ev_idx       = '0;
        ev_time      = '0;
        end_hit      = 1'b0;
        misc_code    = plt_pkg::EV_STATUS;
        misc_idx     = '0;
        misc_time    = '0;

        unique case (req_data.action) inside
            plt_pkg::ACT_SAMPLE:
            begin
                if (armed_reg)
                begin
                    if (!inside_reg && (req_data.distance < enter_thr_reg))
                    begin
                        inside_next = 1'b1;
                        if (!started_reg)
                        begin
                            started_next = 1'b1;
                            start_next   = req_data.now_ms;
                            ev_hit       = 1'b1;
                            ev_code      = plt_pkg::EV_STARTED;
                        end
                        else if (count_reg < CW'(plt_pkg::LAPS))
                        begin
                            table_next[count_reg[IW-1:0]] = lap_ms;
                            count_next = count_reg + CW'(1);
                            start_next = req_data.now_ms;
                            ev_hit     = 1'b1;
                            ev_code    = plt_pkg::EV_LAP;
                            ev_idx     = 2'(count_reg);
                            ev_time    = lap_ms;
                        end
                        else if (test_reg)
                        begin
                            // full table in test mode: drop oldest
                            for (int i = 0; i < plt_pkg::LAPS - 1; i++)
                            begin
                                table_next[i] = table_reg[i+1];
                            end
                            table_next[plt_pkg::LAPS-1] = lap_ms;
                            start_next = req_data.now_ms;
                            ev_hit     = 1'b1;
                            ev_code    = plt_pkg::EV_LAP;
                            ev_idx     = 2'(plt_pkg::LAPS - 1);
                            ev_time    = lap_ms;
                        end
                    end
                    else if (inside_reg && (req_data.distance > exit_thr_reg))
                    begin
                        inside_next = 1'b0;
                    end
                    if (!test_reg && (count_next >= CW'(plt_pkg::LAPS)))
                    begin
                        armed_next = 1'b0;
                        end_hit    = 1'b1;
                    end
                end
            end
            plt_pkg::ACT_ARM_NORM, plt_pkg::ACT_ARM_TEST:
            begin
                for (int i = 0; i < plt_pkg::LAPS; i++)
                begin
                    table_next[i] = '0;
                end
                count_next   = '0;
                started_next = 1'b0;
                start_next   = '0;
                inside_next  = 1'b0;
                armed_next   = 1'b1;
                test_next    = (req_data.action == plt_pkg::ACT_ARM_TEST);
            end
            plt_pkg::ACT_STOP:
            begin
                armed_next  = 1'b0;
                inside_next = 1'b0;
            end
            plt_pkg::ACT_PING:
            begin
                misc_code = plt_pkg::EV_PONG;
            end
            plt_pkg::ACT_READ_LAP:
            begin
                misc_code = plt_pkg::EV_READOUT;
                misc_idx  = req_data.lap_select;
                misc_time = sel_ok ? table_reg[sel_idx] : '0;
            end
            default: ;
        endcase
    end

    // Build the one or two results of this request.
    always_comb
    begin
        pair.first.is_inside    = inside_next;
        pair.first.laps_done    = 3'(count_next);
        pair.first.in_test      = test_next;
        pair.second.event_res   = plt_pkg::EV_END;
        pair.second.lap_index   = '0;
        pair.second.lap_time_ms = '0;
        pair.second.is_armed    = armed_next;
        pair.second.is_inside   = inside_next;
        pair.second.laps_done   = 3'(count_next);
        pair.second.in_test     = test_next;
        pair.second.last        = 1'b1;
        pair.two                = ev_hit && end_hit;

        if (ev_hit)
        begin
            // gate event is reported before any disarm
            pair.first.event_res   = ev_code;
            pair.first.lap_index   = ev_idx;
            pair.first.lap_time_ms = ev_time;
            pair.first.is_armed    = armed_reg;
            pair.first.last        = !end_hit;
        end
        else if (end_hit)
        begin
            pair.first.event_res   = plt_pkg::EV_END;
            pair.first.lap_index   = '0;
            pair.first.lap_time_ms = '0;
            pair.first.is_armed    = armed_next;
            pair.first.last        = 1'b1;
        end
        else
        begin
            pair.first.event_res   = misc_code;
            pair.first.lap_index   = misc_idx;
            pair.first.lap_time_ms = misc_time;
            pair.first.is_armed    = armed_next;
            pair.first.last        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            armed_reg   <= 1'b0;
            inside_reg  <= 1'b0;
            test_reg    <= 1'b0;
            started_reg <= 1'b0;
            start_reg   <= '0;
            count_reg   <= '0;
            for (int i = 0; i < plt_pkg::LAPS; i++)
            begin
                table_reg[i] <= '0;
            end
        end
        else if (req_fire)
        begin
            armed_reg   <= armed_next;
            inside_reg  <= inside_next;
            test_reg    <= test_next;
            started_reg <= started_next;
            start_reg   <= start_next;
            count_reg   <= count_next;
            table_reg   <= table_next;
        end
    end

    // ---------------- result queue ----------------
    // Two entries, each holding all results of one request.
    plt_pkg::rsp_pair_t q_reg [2];
    logic [1:0] q_cnt_reg,  q_cnt_next;
    logic       head_reg,   head_next;
    logic       tail_reg,   tail_next;
    logic       sub_reg,    sub_next;
    logic       rsp_fire;
    logic       pop;

    assign req_stall = (q_cnt_reg == 2'd2);
    assign req_fire  = req_valid && !req_stall;
    assign rsp_valid = (q_cnt_reg != 2'd0);
    assign rsp_data  = sub_reg ? q_reg[head_reg].second : q_reg[head_reg].first;
    assign rsp_fire  = rsp_valid && !rsp_stall;
    assign pop       = rsp_fire && (sub_reg || !q_reg[head_reg].two);

    always_comb
    begin
        head_next  = pop ? !head_reg : head_reg;
        tail_next  = req_fire ? !tail_reg : tail_reg;
        sub_next   = pop ? 1'b0 : (rsp_fire ? 1'b1 : sub_reg);
        q_cnt_next = q_cnt_reg + 2'(req_fire) - 2'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            q_cnt_reg <= '0;
            head_reg  <= 1'b0;
            tail_reg  <= 1'b0;
            sub_reg   <= 1'b0;
        end
        else
        begin
            q_cnt_reg <= q_cnt_next;
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            sub_reg   <= sub_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            q_reg[tail_reg] <= pair;
        end
    end

    // ---------------- checks ----------------
    a_end_disarmed: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_data.event_res == plt_pkg::EV_END) |-> !rsp_data.is_armed)
        else $error("end result shows block still armed");

    a_normal_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        armed_reg && !test_reg |-> (count_reg < CW'(plt_pkg::LAPS)))
        else $error("armed in normal mode with a full lap table");

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(plt_pkg::LAPS))
        else $error("lap count beyond table depth");

    a_second_follows: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_fire && !rsp_data.last |=> rsp_valid && sub_reg)
        else $error("second result of a request not offered");

endmodule
